// File: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none
package tcw_pkg;

    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CELL_W   = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] ATTR_NORMAL  = 8'h07;

    localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_NORMAL, CH_SPACE};

    typedef struct packed {
        logic accept;
        logic exec;
        logic cnt_clr;
        logic clr_step;
        logic scr_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scroll_need;
        logic            cnt_last;
        logic            out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: src/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/tcw_ctrl.sv
// Controller state machine for the text console writer.
`default_nettype none
module tcw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire tcw_pkg::t_sts i_sts,
    output tcw_pkg::t_cmd      o_cmd
);

    import tcw_pkg::*;

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_from_op, n_from_op;

    always_comb begin
        n_state   = r_state;
        n_from_op = r_from_op;
        o_cmd     = '0;
        o_ready   = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state   = r_from_op ? S_FIN : S_IDLE;
                    n_from_op = 1'b0;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_sts.op)
                    OP_PUT: begin
                        if (i_sts.scroll_need) begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_SCROLL;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_from_op     = 1'b1;
                        n_state       = S_CLR;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SCROLL: begin
                o_cmd.scr_step = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_from_op <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_from_op <= n_from_op;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_EXEC)
        else $error("accepted request did not start execution");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free && r_state == S_FIN)
        else $error("result loaded while output register busy");

    a_reset_sweep: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> r_state == S_CLR && !r_from_op)
        else $error("reset did not start the clearing sweep");

endmodule
`default_nettype wire

// File: src/tcw_dp.sv
// Datapath: cursor, screen memory, sweep counter and result register.
`default_nettype none
module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcw_pkg::t_cmd                 i_cmd,
    output tcw_pkg::t_sts                      o_sts,
    input  wire logic [tcw_pkg::OP_W-1:0]      i_op,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]     i_cell_index,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [tcw_pkg::CHAR_W-1:0]    o_cell_char,
    output logic      [tcw_pkg::CHAR_W-1:0]    o_cell_attr,
    output logic      [tcw_pkg::IDX_W-1:0]     o_cursor_pos
);

    import tcw_pkg::*;

    localparam int NCELLS = ROWS * COLUMNS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int COPY_N = NCELLS - COLUMNS;

    // latched request
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [IDX_W-1:0]  r_idx;

    // cursor as row, column and row base address
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_base;

    logic [AW-1:0] r_cnt;
    logic          r_pend;
    logic          r_pend_blank;
    logic [AW-1:0] r_pend_addr;

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic [CHAR_W-1:0] r_out_attr;
    logic [IDX_W-1:0]  r_out_cur;

    logic [AW-1:0]     w_cur;
    logic              w_cur_zero;
    logic              w_row_last;
    logic              w_col_last;
    logic              w_is_nl;
    logic              w_is_bs;
    logic              w_in_range;
    logic              w_copy;
    logic [AW:0]       w_ahead;
    logic              w_out_free;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [CELL_W-1:0] w_rdata;

    assign w_cur      = r_base + AW'(r_col);
    assign w_cur_zero = (r_base == '0) && (r_col == '0);
    assign w_row_last = r_row == RW'(ROWS - 1);
    assign w_col_last = r_col == CW'(COLUMNS - 1);
    assign w_is_nl    = r_ch == CH_NEWLINE;
    assign w_is_bs    = r_ch == CH_BACKSPACE;
    assign w_in_range = 32'(r_idx) < 32'(NCELLS);
    assign w_copy     = r_cnt < AW'(COPY_N);
    assign w_ahead    = {1'b0, r_cnt} + (AW+1)'(COLUMNS);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_sts.op          = r_op;
    assign o_sts.scroll_need = (r_op == OP_PUT) && w_row_last
                               && (w_is_nl || (!w_is_bs && w_col_last));
    assign o_sts.cnt_last    = r_cnt == AW'(NCELLS - 1);
    assign o_sts.out_free    = w_out_free;

    // memory write and read port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = BLANK_CELL;
        w_re    = 1'b0;
        w_raddr = AW'(r_idx);
        if (r_pend) begin
            w_we    = 1'b1;
            w_waddr = r_pend_addr;
            w_wdata = r_pend_blank ? BLANK_CELL : w_rdata;
        end else if (i_cmd.clr_step) begin
            w_we    = 1'b1;
            w_waddr = r_cnt;
        end else if (i_cmd.exec && r_op == OP_PUT && !w_is_nl) begin
            if (w_is_bs) begin
                w_we    = !w_cur_zero;
                w_waddr = w_cur - AW'(1);
            end else begin
                w_we    = 1'b1;
                w_waddr = w_cur;
                w_wdata = {ATTR_NORMAL, r_ch};
            end
        end
        if (i_cmd.scr_step) begin
            w_re    = w_copy;
            w_raddr = w_ahead[AW-1:0];
        end else if (i_cmd.exec && r_op == OP_READ) begin
            w_re    = 1'b1;
            w_raddr = AW'(r_idx);
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_ch  <= i_char_code;
            r_idx <= i_cell_index;
        end
        r_pend_addr  <= r_cnt;
        r_pend_blank <= !w_copy;
        if (i_cmd.out_load) begin
            r_out_cur <= IDX_W'(w_cur);
            if (r_op == OP_READ && w_in_range) begin
                r_out_char <= w_rdata[CHAR_W-1:0];
                r_out_attr <= w_rdata[CELL_W-1:CHAR_W];
            end else begin
                r_out_char <= '0;
                r_out_attr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.scr_step;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.scr_step) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.clr_step) begin
                r_row  <= '0;
                r_col  <= '0;
                r_base <= '0;
            end else if (i_cmd.exec && r_op == OP_PUT) begin
                if (w_is_nl) begin
                    r_col <= '0;
                    if (!w_row_last) begin
                        r_row  <= r_row + RW'(1);
                        r_base <= r_base + AW'(COLUMNS);
                    end
                end else if (w_is_bs) begin
                    if (!w_cur_zero) begin
                        if (r_col == '0) begin
                            r_col  <= CW'(COLUMNS - 1);
                            r_row  <= r_row - RW'(1);
                            r_base <= r_base - AW'(COLUMNS);
                        end else begin
                            r_col <= r_col - CW'(1);
                        end
                    end
                end else if (w_col_last) begin
                    r_col <= '0;
                    if (!w_row_last) begin
                        r_row  <= r_row + RW'(1);
                        r_base <= r_base + AW'(COLUMNS);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_cursor_pos = r_out_cur;

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> {1'b0, w_waddr} < (AW+1)'(NCELLS))
        else $error("memory write beyond last cell");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(COLUMNS - 1) && r_row <= RW'(ROWS - 1)
        && r_base == AW'(32'(r_row) * COLUMNS))
        else $error("cursor row, column and base disagree");

    a_scroll_write_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(i_cmd.scr_step) && r_pend_addr == $past(r_cnt))
        else $error("scroll write lost its read");

endmodule
`default_nettype wire

// File: src/text_console_writer.sv
// Text console writer: a put or read is accepted, executed, then its result is loaded into the output register.
// The result load waits while the output register is held; the controller takes no new request until then.
// A clear adds a blanking sweep over all ROWS*COLUMNS cells; a scrolling put adds a copy sweep and a drain state.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with s_axis_tready low.
// Reset is synchronous, active low; the cursor homes and every cell becomes a blank.
`default_nettype none
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // op[1:0], char_code[9:2], cell_index[20:10], zero pad
    input  wire logic [tcw_pkg::S_DATA_W-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // cell_char[7:0], cell_attr[15:8], cursor_pos[26:16], zero pad
    output logic      [tcw_pkg::M_DATA_W-1:0]     m_axis_tdata
);

    import tcw_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [CHAR_W-1:0] w_cell_char;
    logic [CHAR_W-1:0] w_cell_attr;
    logic [IDX_W-1:0]  w_cursor_pos;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (s_axis_tdata[OP_W-1:0]),
        .i_char_code  (s_axis_tdata[OP_W+CHAR_W-1:OP_W]),
        .i_cell_index (s_axis_tdata[OP_W+CHAR_W+IDX_W-1:OP_W+CHAR_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_cell_char  (w_cell_char),
        .o_cell_attr  (w_cell_attr),
        .o_cursor_pos (w_cursor_pos)
    );

    assign m_axis_tdata = {(M_DATA_W - 2*CHAR_W - IDX_W)'(0),
                           w_cursor_pos, w_cell_attr, w_cell_char};

endmodule
`default_nettype wire

// File: verif/text_console_writer_tb.sv
// Self-checking testbench for text_console_writer: directed and random console traffic.
`default_nettype none
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int NCELLS  = COLUMNS * ROWS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] cell_attr;
        logic [CHAR_W-1:0] cell_char;
    } console_result_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // console image and cursor as the block should hold them
    logic [CELL_W-1:0] screen_image [NCELLS];
    int                cursor_q;

    console_result_t   predicted_results[$];

    int error_count   = 0;
    int checked_count = 0;
    int scroll_count  = 0;
    int put_count     = 0;
    int read_count    = 0;
    int clear_count   = 0;
    int unused_count  = 0;
    int burst_left    = 0;
    int stall_mode    = 0;
    int stall_cycle   = 0;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void console_blank_all();
        for (int i = 0; i < NCELLS; i++) begin
            screen_image[i] = BLANK_CELL;
        end
        cursor_q = 0;
    endfunction

    function automatic console_result_t console_step(input logic [OP_W-1:0] op,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [IDX_W-1:0] idx);
        console_result_t r;
        r = '0;
        case (op)
            OP_PUT: begin
                if (ch == CH_NEWLINE) begin
                    cursor_q = (cursor_q / COLUMNS + 1) * COLUMNS;
                end else if (ch == CH_BACKSPACE) begin
                    if (cursor_q > 0) begin
                        cursor_q--;
                        screen_image[cursor_q] = BLANK_CELL;
                    end
                end else begin
                    screen_image[cursor_q] = {ATTR_NORMAL, ch};
                    cursor_q++;
                end
                if (cursor_q >= NCELLS) begin
                    for (int i = 0; i < NCELLS - COLUMNS; i++) begin
                        screen_image[i] = screen_image[i + COLUMNS];
                    end
                    for (int i = NCELLS - COLUMNS; i < NCELLS; i++) begin
                        screen_image[i] = BLANK_CELL;
                    end
                    cursor_q = NCELLS - COLUMNS;
                    scroll_count++;
                end
            end
            OP_READ: begin
                if (idx < NCELLS) begin
                    {r.cell_attr, r.cell_char} = screen_image[idx];
                end
            end
            OP_CLEAR: begin
                console_blank_all();
            end
            default: begin
            end
        endcase
        r.cursor_pos = cursor_q[IDX_W-1:0];
        return r;
    endfunction

    task automatic push_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, idx, ch, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted_results.push_back(console_step(op, ch, idx));
        case (op)
            OP_PUT:   put_count++;
            OP_READ:  read_count++;
            OP_CLEAR: clear_count++;
            default:  unused_count++;
        endcase
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (predicted_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: ready pattern switches among four modes: always ready, random, and two periodic windows
    always @(posedge i_clk) begin
        if (stall_cycle % 400 == 0) stall_mode = $urandom_range(0, 3);
        stall_cycle++;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (stall_cycle % 7) < 2;
            default: m_axis_tready <= (stall_cycle % 64) >= 40;
        endcase
    end

    always @(posedge i_clk) begin
        console_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_results.size() == 0) begin
                $error("result with nothing pending: tdata %0h", m_axis_tdata);
                error_count++;
            end else begin
                want = predicted_results.pop_front();
                checked_count++;
                if (m_axis_tdata[7:0] !== want.cell_char) begin
                    $error("cell_char: expected %0h, got %0h", want.cell_char,
                           m_axis_tdata[7:0]);
                    error_count++;
                end
                if (m_axis_tdata[15:8] !== want.cell_attr) begin
                    $error("cell_attr: expected %0h, got %0h", want.cell_attr,
                           m_axis_tdata[15:8]);
                    error_count++;
                end
                if (m_axis_tdata[26:16] !== want.cursor_pos) begin
                    $error("cursor_pos: expected %0d, got %0d", want.cursor_pos,
                           m_axis_tdata[26:16]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_contents();
        push_request(OP_READ, 8'h00, 11'd0);
        push_request(OP_READ, 8'hFF, 11'd1999);
        push_request(OP_READ, 8'h00, 11'd2000);
        push_request(OP_READ, 8'h55, 11'd2047);
        push_request(OP_UNUSED, 8'hFF, 11'h7FF);
    endtask

    task automatic test_put_and_erase();
        push_request(OP_PUT, 8'h41, 11'd0);
        push_request(OP_PUT, 8'hFF, 11'h7FF);
        push_request(OP_PUT, 8'h00, 11'd0);
        push_request(OP_READ, 8'h00, 11'd1);
        push_request(OP_PUT, CH_BACKSPACE, 11'd0);
        push_request(OP_READ, 8'h00, 11'd2);
        push_request(OP_PUT, CH_NEWLINE, 11'd0);
        push_request(OP_READ, 8'h00, 11'd0);
    endtask

    task automatic test_clear_screen();
        wait_results_drained();
        push_request(OP_CLEAR, 8'hAA, 11'h555);
        push_request(OP_READ, 8'h00, 11'd0);
        push_request(OP_PUT, CH_BACKSPACE, 11'd0);
    endtask

    task automatic test_scroll_on_newline();
        push_request(OP_PUT, 8'h54, 11'd0);
        push_request(OP_PUT, CH_NEWLINE, 11'd0);
        push_request(OP_PUT, 8'h55, 11'd0);
        repeat (23) push_request(OP_PUT, CH_NEWLINE, 11'd0);
        push_request(OP_PUT, 8'h56, 11'd0);
        push_request(OP_PUT, CH_NEWLINE, 11'd0);
        push_request(OP_READ, 8'h00, 11'd0);
        push_request(OP_READ, 8'h00, 11'd1840);
    endtask

    task automatic test_random_text(input int n_items);
        int          roll;
        int          nl_pct;
        int          lo;
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [10:0] idx;
        nl_pct = 3;
        for (int k = 0; k < n_items; k++) begin
            if (k % 300 == 0) begin
                wait_results_drained();
                nl_pct = $urandom_range(0, 1) ? 25 : 3;
            end
            ch   = 8'($urandom_range(0, 255));
            idx  = 11'($urandom_range(0, 2047));
            roll = $urandom_range(0, 999);
            if (roll < 560) begin
                op   = OP_PUT;
                roll = $urandom_range(0, 99);
                if (roll < nl_pct) ch = CH_NEWLINE;
                else if (roll < nl_pct + 5) ch = CH_BACKSPACE;
                else if (roll < 85) ch = 8'($urandom_range(8'h21, 8'h7E));
            end else if (roll < 960) begin
                op   = OP_READ;
                roll = $urandom_range(0, 99);
                if (roll < 40) begin
                    lo  = (cursor_q > 3) ? cursor_q - 3 : 0;
                    idx = 11'($urandom_range(lo, cursor_q + 1));
                end else if (roll < 60) begin
                    idx = 11'($urandom_range(NCELLS - 2 * COLUMNS, NCELLS - 1));
                end else if (roll < 90) begin
                    idx = 11'($urandom_range(0, NCELLS - 1));
                end else begin
                    idx = 11'($urandom_range(NCELLS, 2047));
                end
            end else if (roll < 963) begin
                op = OP_CLEAR;
            end else begin
                op = OP_UNUSED;
            end
            push_request(op, ch, idx);
        end
    endtask

    initial begin
        console_blank_all();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_contents();
        test_put_and_erase();
        test_clear_screen();
        test_scroll_on_newline();
        test_random_text(1950);
        wait_results_drained();
        repeat (16) @(posedge i_clk);
        $display("requests: %0d put, %0d read, %0d clear, %0d unused op; %0d scrolls",
                 put_count, read_count, clear_count, unused_count, scroll_count);
        $display("results compared: %0d, failures: %0d", checked_count, error_count);
        if (error_count == 0) begin
            $display("text_console_writer_tb: done, clean");
        end else begin
            $display("text_console_writer_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #500000000;
        $display("text_console_writer_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
